// ===== rtl/core/lgme_pkg.sv =====
// shared types, constants and helpers of the light gesture move encoder
`default_nettype none

package lgme_pkg;

  localparam int unsigned SampleW = 8;
  localparam int unsigned NumSensors = 4;
  localparam int unsigned CountW = 16;
  localparam int unsigned CodeW = 8;
  localparam int unsigned ApbAddrW = 3;
  localparam int unsigned ApbDataW = 32;

  localparam logic [SampleW-1:0] BrightThrRst = 8'd50;
  localparam logic [SampleW-1:0] ShadeThrRst = 8'd120;

  localparam logic [CodeW-1:0] CodeNone = 8'h00;
  localparam logic [CodeW-1:0] CodeUndef = 8'h01;
  localparam logic [CodeW-1:0] CodeLeft = 8'h61;
  localparam logic [CodeW-1:0] CodeRight = 8'h64;
  localparam logic [CodeW-1:0] CodeDown = 8'h73;
  localparam logic [CodeW-1:0] CodeRotate = 8'h77;

  typedef enum logic {
    REG_BRIGHT_THR = 1'b0,
    REG_SHADE_THR  = 1'b1
  } reg_idx_e;

  typedef enum logic {
    CMD_SAMPLES = 1'b0,
    CMD_TICK    = 1'b1
  } cmd_e;

  typedef enum logic [2:0] {
    MV_NONE   = 3'd0,
    MV_UNDEF  = 3'd1,
    MV_ROTATE = 3'd2,
    MV_RIGHT  = 3'd3,
    MV_LEFT   = 3'd4,
    MV_DOWN   = 3'd5
  } move_e;

  typedef struct packed {
    logic  any;
    logic  single;
    move_e pick;
  } sense_t;

  function automatic logic [CodeW-1:0] code_of(input move_e mv);
    logic [CodeW-1:0] code;
    case (mv)
      MV_NONE:   code = CodeNone;
      MV_ROTATE: code = CodeRotate;
      MV_RIGHT:  code = CodeRight;
      MV_LEFT:   code = CodeLeft;
      MV_DOWN:   code = CodeDown;
      default:   code = CodeUndef;
    endcase
    return code;
  endfunction

  function automatic logic move_valid(input move_e mv);
    return (mv == MV_ROTATE) || (mv == MV_RIGHT) || (mv == MV_LEFT) || (mv == MV_DOWN);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/lgme_sense.sv =====
// sensor classification: shaded flags, shaded count and single-sensor move pick
`default_nettype none

module lgme_sense
  import lgme_pkg::*;
(
  input  wire logic [SampleW-1:0] sample_bottom_i,
  input  wire logic [SampleW-1:0] sample_left_i,
  input  wire logic [SampleW-1:0] sample_right_i,
  input  wire logic [SampleW-1:0] sample_top_i,
  input  wire logic [SampleW-1:0] bright_thr_i,
  input  wire logic [SampleW-1:0] shade_thr_i,
  output sense_t                  sense_o
);

  logic [SampleW-1:0]    samples [NumSensors];
  logic [NumSensors-1:0] shaded;
  logic [2:0]            nshaded;
  move_e                 pick;

  assign samples[0] = sample_bottom_i;
  assign samples[1] = sample_left_i;
  assign samples[2] = sample_right_i;
  assign samples[3] = sample_top_i;

  always_comb begin
    for (int i = 0; i < NumSensors; i++) begin
      shaded[i] = (samples[i] >= bright_thr_i) && (samples[i] > shade_thr_i);
    end
  end

  assign nshaded = 3'(shaded[0]) + 3'(shaded[1]) + 3'(shaded[2]) + 3'(shaded[3]);

  always_comb begin
    if (shaded[0]) begin
      pick = MV_ROTATE;
    end else if (shaded[1]) begin
      pick = MV_RIGHT;
    end else if (shaded[2]) begin
      pick = MV_LEFT;
    end else begin
      pick = MV_DOWN;
    end
  end

  assign sense_o.any    = |shaded;
  assign sense_o.single = (nshaded == 3'd1);
  assign sense_o.pick   = pick;

endmodule

`default_nettype wire

// ===== rtl/core/light_gesture_move_encoder_core.sv =====
// top level of the light gesture move encoder: request staging, move state and result register
//
// usage
//   input stream (s_*): one request per handshake; s_tuser holds cmd (0 = four samples,
//   1 = repeat tick), s_tdata holds the four 8-bit samples. a sample request updates the
//   move state and emits the move byte when a single shaded sensor starts a move; a tick
//   arms the hold flag once, then re-emits the current move with its repeat count.
//   output stream (m_*): m_tdata holds move_code and the 16-bit repeat_count.
//   config port (apb): bright threshold at address 0, shade threshold at address 4;
//   write only while the block is idle.
// timing
//   a request is held in an input register and resolved into the result register once
//   that register is free or being taken; the result is offered from the result register.
//   one request per cycle is accepted; the input and result registers form a two-entry
//   pipeline, so s_tready stays high while the result register is free or being taken.
// reset and stall
//   reset clears the move state, hold flag, counter and both pipeline valids and loads
//   the thresholds with 50 and 120. when m_tready is low with a result waiting, one more
//   request is taken into the input register and then s_tready drops until m_tready rises.
`default_nettype none

module light_gesture_move_encoder_core
  import lgme_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // input stream
  input  wire logic                s_tvalid,
  output logic                     s_tready,
  input  wire logic [31:0]         s_tdata,   // sample_bottom, sample_left, sample_right, sample_top
  input  wire logic                s_tuser,   // cmd
  // output stream
  output logic                     m_tvalid,
  input  wire logic                m_tready,
  output logic [23:0]              m_tdata,   // move_code, repeat_count
  // config port
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [ApbAddrW-1:0] paddr,
  input  wire logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0]      prdata,
  output logic                     pready
);

  logic [SampleW-1:0] bright_thr_q, shade_thr_q;
  reg_idx_e           reg_idx;
  logic               cfg_wr;

  logic               in_valid_q;
  logic [31:0]        in_data_q;
  cmd_e               in_cmd_q;
  logic               advance;

  move_e              move_q, move_d;
  logic               hold_q, hold_d;
  logic [CountW-1:0]  cnt_q, cnt_d;
  logic               emit;
  logic [CodeW-1:0]   res_code;
  logic [CountW-1:0]  res_cnt;

  logic               out_valid_q;
  logic [CodeW-1:0]   out_code_q;
  logic [CountW-1:0]  out_cnt_q;

  sense_t             sense;

  // config registers
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    case (reg_idx)
      REG_BRIGHT_THR: prdata = ApbDataW'(bright_thr_q);
      REG_SHADE_THR:  prdata = ApbDataW'(shade_thr_q);
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bright_thr_q <= BrightThrRst;
      shade_thr_q  <= ShadeThrRst;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_BRIGHT_THR: bright_thr_q <= pwdata[SampleW-1:0];
        REG_SHADE_THR:  shade_thr_q  <= pwdata[SampleW-1:0];
        default:        ;
      endcase
    end
  end

  // input register
  assign advance  = !out_valid_q || m_tready;
  assign s_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_tready) begin
      in_valid_q <= s_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_tready && s_tvalid) begin
      in_data_q <= s_tdata;
      in_cmd_q  <= cmd_e'(s_tuser);
    end
  end

  lgme_sense u_sense (
    .sample_bottom_i (in_data_q[7:0]),
    .sample_left_i   (in_data_q[15:8]),
    .sample_right_i  (in_data_q[23:16]),
    .sample_top_i    (in_data_q[31:24]),
    .bright_thr_i    (bright_thr_q),
    .shade_thr_i     (shade_thr_q),
    .sense_o         (sense)
  );

  // move state update
  always_comb begin
    move_d   = move_q;
    hold_d   = hold_q;
    cnt_d    = cnt_q;
    emit     = 1'b0;
    res_code = code_of(move_q);
    res_cnt  = cnt_q;
    case (in_cmd_q)
      CMD_TICK: begin
        if (move_valid(move_q)) begin
          if (!hold_q) begin
            hold_d = 1'b1;
          end else begin
            emit = 1'b1;
            if (cnt_q != '1) begin
              cnt_d = cnt_q + CountW'(1);
            end
          end
        end
      end
      CMD_SAMPLES: begin
        if (!sense.any) begin
          move_d = MV_NONE;
          hold_d = 1'b0;
        end else if (move_q == MV_NONE) begin
          hold_d = 1'b0;
          if (sense.single) begin
            move_d   = sense.pick;
            cnt_d    = CountW'(1);
            emit     = 1'b1;
            res_code = code_of(sense.pick);
            res_cnt  = CountW'(1);
          end else begin
            move_d = MV_UNDEF;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      move_q      <= MV_NONE;
      hold_q      <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q && emit;
      if (in_valid_q) begin
        move_q <= move_d;
        hold_q <= hold_d;
        cnt_q  <= cnt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_valid_q && emit) begin
      out_code_q <= res_code;
      out_cnt_q  <= res_cnt;
    end
  end

  assign m_tvalid = out_valid_q;
  assign m_tdata  = {out_cnt_q, out_code_q};

  // checks
  a_result_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid |-> (m_tdata[23:8] != '0))
    else $error("result with zero repeat count");

  a_hold_needs_move: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hold_q |-> move_valid(move_q))
    else $error("hold flag set without a valid move");

  a_move_has_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    move_valid(move_q) |-> (cnt_q != '0))
    else $error("valid move with zero repeat counter");

endmodule

`default_nettype wire

// ===== bench/light_gesture_move_encoder_checker.sv =====
// checker for the light gesture move encoder: tracks the gesture state and compares every result
module light_gesture_move_encoder_checker
  import lgme_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_tvalid,
  input  logic                s_tready,
  input  logic [31:0]         s_tdata,   // sample_bottom, sample_left, sample_right, sample_top
  input  logic                s_tuser,   // cmd
  input  logic                m_tvalid,
  input  logic                m_tready,
  input  logic [23:0]         m_tdata,   // move_code, repeat_count
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  input  logic                pready,
  output int                  error_count,
  output int                  pending_count,
  output int                  request_count,
  output int                  result_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [CodeW-1:0]  code;
    logic [CountW-1:0] count;
  } move_report_t;

  move_report_t         expected_reports[$];
  logic [SampleW-1:0]   low_cut;
  logic [SampleW-1:0]   high_cut;
  move_e                gesture;
  logic                 armed;
  logic [CountW-1:0]    repeats;

  function automatic logic [CodeW-1:0] byte_for(input move_e mv);
    logic [CodeW-1:0] b;
    case (mv)
      MV_NONE:   b = CodeNone;
      MV_ROTATE: b = CodeRotate;
      MV_RIGHT:  b = CodeRight;
      MV_LEFT:   b = CodeLeft;
      MV_DOWN:   b = CodeDown;
      default:   b = CodeUndef;
    endcase
    return b;
  endfunction

  function automatic bit gesture_live(input move_e mv);
    return mv >= MV_ROTATE && mv <= MV_DOWN;
  endfunction

  function automatic bit is_dark(input logic [SampleW-1:0] v);
    return v >= low_cut && v > high_cut;
  endfunction

  task automatic track_gesture(input cmd_e cmd, input logic [31:0] samples);
    int    n_dark;
    int    first;
    move_e prior;
    n_dark = 0;
    first = 0;
    if (cmd == CMD_TICK) begin
      if (!gesture_live(gesture)) return;
      if (!armed) begin
        armed = 1'b1;
        return;
      end
      expected_reports.push_back('{code: byte_for(gesture), count: repeats});
      if (repeats != '1) repeats = repeats + 1'b1;
      return;
    end
    for (int i = 0; i < NumSensors; i++) begin
      if (is_dark(samples[SampleW*i +: SampleW])) begin
        if (n_dark == 0) first = i;
        n_dark++;
      end
    end
    prior = gesture;
    if (n_dark == 0) begin
      gesture = MV_NONE;
      armed = 1'b0;
    end else if (gesture == MV_NONE) begin
      armed = 1'b0;
      if (n_dark > 1) gesture = MV_UNDEF;
      else begin
        case (first)
          0:       gesture = MV_ROTATE;
          1:       gesture = MV_RIGHT;
          2:       gesture = MV_LEFT;
          default: gesture = MV_DOWN;
        endcase
      end
    end
    if (prior == MV_NONE && gesture_live(gesture)) begin
      repeats = CountW'(1);
      expected_reports.push_back('{code: byte_for(gesture), count: CountW'(1)});
    end
  endtask

  always @(posedge clk_i) begin
    move_report_t want;
    if (!rst_ni) begin
      expected_reports.delete();
      low_cut = BrightThrRst;
      high_cut = ShadeThrRst;
      gesture = MV_NONE;
      armed = 1'b0;
      repeats = '0;
      error_count = 0;
      request_count = 0;
      result_count = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        result_count++;
        if (expected_reports.size() == 0) begin
          $error("result with nothing expected: move_code %h repeat_count %0d",
                 m_tdata[7:0], m_tdata[23:8]);
          error_count++;
        end else begin
          want = expected_reports.pop_front();
          if (m_tdata[7:0] !== want.code) begin
            $error("move_code expected %h actual %h", want.code, m_tdata[7:0]);
            error_count++;
          end
          if (m_tdata[23:8] !== want.count) begin
            $error("repeat_count expected %0d actual %0d", want.count, m_tdata[23:8]);
            error_count++;
          end
        end
      end
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_e'(paddr[2]))
          REG_BRIGHT_THR: low_cut = pwdata[SampleW-1:0];
          REG_SHADE_THR:  high_cut = pwdata[SampleW-1:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        request_count++;
        track_gesture(cmd_e'(s_tuser), s_tdata);
      end
    end
    pending_count = expected_reports.size();
  end

endmodule

// ===== bench/light_gesture_move_encoder_core_tb.sv =====
// testbench top of the light gesture move encoder: clock, reset, stimulus and verdict
module light_gesture_move_encoder_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lgme_pkg::*;

  localparam int IdleLimit = 2000;
  localparam int RandomPerSetting = 90;
  localparam int RepeatTicks = 20;
  localparam int NumSettings = 8;
  localparam logic [7:0] LowSet[NumSettings]  = '{8'd50, 8'd0, 8'd255, 8'd200,
                                                  8'd10, 8'd0, 8'd128, 8'd0};
  localparam logic [7:0] HighSet[NumSettings] = '{8'd120, 8'd0, 8'd0, 8'd100,
                                                  8'd250, 8'd254, 8'd60, 8'd255};

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                s_tvalid;
  logic                s_tready;
  logic [31:0]         s_tdata;
  logic                s_tuser;
  logic                m_tvalid;
  logic                m_tready;
  logic [23:0]         m_tdata;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ApbAddrW-1:0] paddr;
  logic [ApbDataW-1:0] pwdata;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  int         error_count;
  int         pending_count;
  int         request_count;
  int         result_count;
  int         idle_cycles = 0;
  int         settings_used = 0;
  bit         calm;
  logic [7:0] low_now;
  logic [7:0] high_now;

  light_gesture_move_encoder_core dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  light_gesture_move_encoder_checker move_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .s_tuser       (s_tuser),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .pready        (pready),
    .error_count   (error_count),
    .pending_count (pending_count),
    .request_count (request_count),
    .result_count  (result_count)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel || !rst_ni) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("FAIL light_gesture_move_encoder_core");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic int pause_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  // receiver: random stalls plus two long hold-offs that back the block up
  initial begin
    int stall_left;
    int taken;
    int holdoff_at;
    stall_left = 0;
    taken = 0;
    holdoff_at = 40;
    m_tready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (m_tvalid && m_tready) taken++;
      if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else if (holdoff_at != 0 && taken >= holdoff_at) begin
        m_tready <= 1'b0;
        stall_left = 80;
        holdoff_at = (holdoff_at == 40) ? 200 : 0;
      end else if (!calm && $urandom_range(0, 99) < 20) begin
        m_tready <= 1'b0;
        stall_left = pause_len() - 1;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  task automatic send_request(input cmd_e cmd, input logic [7:0] b, input logic [7:0] l,
                              input logic [7:0] r, input logic [7:0] t);
    int gap;
    s_tvalid <= 1'b1;
    s_tuser <= cmd;
    s_tdata <= {t, r, l, b};
    do @(posedge clk_i); while (!s_tready);
    gap = (calm || $urandom_range(0, 99) < 65) ? 0 : pause_len();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_tick();
    send_request(CMD_TICK, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  // picks a sample that is shaded or bright under the cutoffs now in force
  function automatic logic [7:0] level(input bit dark);
    int bright_max;
    bright_max = (int'(low_now) - 1 > int'(high_now)) ? int'(low_now) - 1 : int'(high_now);
    if (dark && bright_max < 255) return 8'($urandom_range(bright_max + 1, 255));
    if (dark) return 8'($urandom);
    return 8'($urandom_range(0, bright_max));
  endfunction

  task automatic random_request();
    int         kind;
    int         n_dark;
    int         r;
    bit [3:0]   mask;
    logic [7:0] s[4];
    kind = $urandom_range(0, 99);
    mask = '0;
    if (kind < 28) begin
      send_tick();
    end else if (kind < 36) begin
      send_request(CMD_SAMPLES, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    end else begin
      r = $urandom_range(0, 99);
      n_dark = (r < 40) ? 0 : (r < 85) ? 1 : $urandom_range(2, 4);
      while ($countones(mask) < n_dark) mask[$urandom_range(0, 3)] = 1'b1;
      for (int i = 0; i < 4; i++) s[i] = level(mask[i]);
      send_request(CMD_SAMPLES, s[0], s[1], s[2], s[3]);
    end
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    do @(negedge clk_i); while (pending_count != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_cutoff(input reg_idx_e idx, input logic [7:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ApbAddrW'({idx, 2'b00});
    pwdata <= {24'($urandom), value};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_BRIGHT_THR) low_now = value;
    else high_now = value;
  endtask

  task automatic apply_setting(input logic [7:0] low, input logic [7:0] high);
    write_cutoff(REG_BRIGHT_THR, low);
    write_cutoff(REG_SHADE_THR, high);
    settings_used++;
  endtask

  initial begin
    rst_ni = 1'b0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = CMD_SAMPLES;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    calm = 1'b0;
    low_now = BrightThrRst;
    high_now = ShadeThrRst;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part under the reset cutoffs
    send_request(CMD_SAMPLES, 8'd0, 8'd0, 8'd0, 8'd0);
    send_request(CMD_TICK, 8'd255, 8'd255, 8'd255, 8'd255);
    send_request(CMD_SAMPLES, 8'd255, 8'd0, 8'd0, 8'd0);
    send_tick();
    send_tick();
    send_tick();
    send_request(CMD_SAMPLES, 8'd0, 8'd255, 8'd255, 8'd0);
    send_tick();
    send_request(CMD_SAMPLES, 8'd50, 8'd120, 8'd49, 8'd0);
    send_request(CMD_SAMPLES, 8'd0, 8'd121, 8'd0, 8'd0);
    send_request(CMD_SAMPLES, 8'd0, 8'd0, 8'd0, 8'd0);
    send_request(CMD_SAMPLES, 8'd0, 8'd0, 8'd200, 8'd0);
    send_tick();
    send_tick();
    send_request(CMD_SAMPLES, 8'd0, 8'd0, 8'd0, 8'd0);
    send_request(CMD_SAMPLES, 8'd0, 8'd0, 8'd0, 8'd255);
    send_tick();
    send_tick();
    send_request(CMD_SAMPLES, 8'd255, 8'd0, 8'd0, 8'd255);
    send_request(CMD_SAMPLES, 8'd0, 8'd0, 8'd0, 8'd0);
    send_request(CMD_SAMPLES, 8'd130, 8'd0, 8'd0, 8'd140);
    send_tick();
    send_tick();
    send_request(CMD_SAMPLES, 8'd0, 8'd0, 8'd0, 8'd0);
    send_request(CMD_SAMPLES, 8'd255, 8'd255, 8'd255, 8'd255);
    drain();

    for (int k = 0; k < NumSettings; k++) begin
      apply_setting(LowSet[k], HighSet[k]);
      calm = (k % 3 == 2);
      repeat (RandomPerSetting) random_request();
      drain();
    end

    // one move held over a run of repeat ticks
    calm = 1'b1;
    apply_setting(BrightThrRst, ShadeThrRst);
    send_request(CMD_SAMPLES, 8'd0, 8'd0, 8'd0, 8'd0);
    send_request(CMD_SAMPLES, 8'd255, 8'd0, 8'd0, 8'd0);
    repeat (RepeatTicks) send_tick();
    send_request(CMD_SAMPLES, 8'd0, 8'd0, 8'd0, 8'd0);
    drain();

    $display("run covered %0d requests under %0d cutoff settings", request_count,
             settings_used);
    $display("%0d move results checked against the predicted stream", result_count);
    if (error_count == 0 && pending_count == 0) begin
      $display("PASS light_gesture_move_encoder_core");
    end else begin
      $display("FAIL light_gesture_move_encoder_core");
    end
    $finish;
  end

endmodule
